[sv/sbts_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbts_pkg
// shared types and constants of the sprite batch texture slotter
// ----------------------------------------------------------------------------
package sbts_pkg;

  // default build values
  localparam int BATCH_VERTICES_DEF = 4096;
  localparam int TEXTURE_SLOTS_DEF  = 32;
  localparam int FRAME_QUADS_DEF    = 65536;

  // geometry of one sprite quad
  localparam int QUAD_VERTS   = 4;
  localparam int QUAD_INDICES = 6;

  // fixed field widths of the streams
  localparam int HANDLE_W = 16;
  localparam int BATCH_W  = 16;
  localparam int SLOT_W   = 5;
  localparam int USED_W   = 6;
  localparam int FVERT_W  = 18;
  localparam int FINDEX_W = 19;
  localparam int VCOUNT_W = 13;
  localparam int ICOUNT_W = 13;

  localparam int OUT_FIELDS_W = BATCH_W + SLOT_W + USED_W + FVERT_W + FINDEX_W
                                + VCOUNT_W + ICOUNT_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_FIELDS_W;

  // most records one quad can cause
  localparam int MAX_RECS = 3;

  typedef enum logic [0:0] {
    REC_QUAD  = 1'b0,
    REC_CLOSE = 1'b1
  } rec_kind_t;

  typedef struct packed {
    rec_kind_t             kind;
    logic [BATCH_W-1:0]    batch;
    logic [SLOT_W-1:0]     slot;
    logic [USED_W-1:0]     used;
    logic [FVERT_W-1:0]    first_vertex;
    logic [FINDEX_W-1:0]   first_index;
    logic [VCOUNT_W-1:0]   vertex_count;
    logic [ICOUNT_W-1:0]   index_count;
    logic                  last;
  } sbts_rec_t;

  // records produced for one accepted quad, first in entry 0
  typedef struct packed {
    logic [1:0]                  num;
    sbts_rec_t [MAX_RECS-1:0]    rec;
  } sbts_load_t;

endpackage : sbts_pkg
`default_nettype wire

[sv/sbts_slot_cam.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbts_slot_cam
// texture slot store with a parallel compare over the occupied slots
// ----------------------------------------------------------------------------
module sbts_slot_cam
  import sbts_pkg::*;
#(
  parameter int TEXTURE_SLOTS = TEXTURE_SLOTS_DEF,
  localparam int FW = $clog2(TEXTURE_SLOTS + 1),
  localparam int SW = (TEXTURE_SLOTS > 1) ? $clog2(TEXTURE_SLOTS) : 1
) (
  input  wire logic                clk,
  input  wire logic [HANDLE_W-1:0] handle,
  input  wire logic [FW-1:0]       fill,
  input  wire logic                wr_en,
  input  wire logic [SW-1:0]       wr_slot,
  output logic                     hit,
  output logic [SW-1:0]            hit_slot
);

  logic [HANDLE_W-1:0] img_r [TEXTURE_SLOTS];
  logic [TEXTURE_SLOTS-1:0] match;

  // only slots below the fill count are live
  always_comb begin
    for (int i = 0; i < TEXTURE_SLOTS; i++) begin
      match[i] = (FW'(i) < fill) && (img_r[i] == handle);
    end
  end

  // lowest matching slot wins
  always_comb begin
    hit      = 1'b0;
    hit_slot = '0;
    for (int i = TEXTURE_SLOTS - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit      = 1'b1;
        hit_slot = SW'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      img_r[wr_slot] <= handle;
    end
  end

endmodule : sbts_slot_cam
`default_nettype wire

[sv/sbts_batch_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbts_batch_ctrl
// batch state, split decisions and record building for one quad per cycle while accept is high
// ----------------------------------------------------------------------------
module sbts_batch_ctrl
  import sbts_pkg::*;
#(
  parameter int BATCH_VERTICES = BATCH_VERTICES_DEF,
  parameter int TEXTURE_SLOTS  = TEXTURE_SLOTS_DEF,
  parameter int FRAME_QUADS    = FRAME_QUADS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                accept,
  input  wire logic [HANDLE_W-1:0] image_handle,
  input  wire logic                frame_end,
  output sbts_load_t               load
);

  localparam int VMOD = QUAD_VERTS * FRAME_QUADS;
  localparam int IMOD = QUAD_INDICES * FRAME_QUADS;
  localparam int VW   = $clog2(VMOD);
  localparam int IW   = $clog2(IMOD);
  localparam int FW   = $clog2(TEXTURE_SLOTS + 1);
  localparam int SW   = (TEXTURE_SLOTS > 1) ? $clog2(TEXTURE_SLOTS) : 1;
  localparam int BVW  = $clog2(BATCH_VERTICES + 1);
  localparam int CW   = (VW > BVW) ? VW : BVW;

  localparam logic [VW:0] VMOD_L = (VW + 1)'(VMOD);
  localparam logic [IW:0] IMOD_L = (IW + 1)'(IMOD);

  function automatic logic [VW-1:0] vdist(logic [VW-1:0] p, logic [VW-1:0] s);
    logic [VW:0] d;
    if (p >= s) d = {1'b0, p} - {1'b0, s};
    else        d = {1'b0, p} + (VMOD_L - {1'b0, s});
    return d[VW-1:0];
  endfunction

  function automatic logic [IW-1:0] idist(logic [IW-1:0] p, logic [IW-1:0] s);
    logic [IW:0] d;
    if (p >= s) d = {1'b0, p} - {1'b0, s};
    else        d = {1'b0, p} + (IMOD_L - {1'b0, s});
    return d[IW-1:0];
  endfunction

  logic [FW-1:0]      fill_r,   fill_nxt;
  logic [BATCH_W-1:0] batch_r,  batch_nxt;
  logic [VW-1:0]      vpos_r,   vpos_nxt;
  logic [IW-1:0]      ipos_r,   ipos_nxt;
  logic [VW-1:0]      vstart_r, vstart_nxt;
  logic [IW-1:0]      istart_r, istart_nxt;

  logic          hit, hit_eff;
  logic [SW-1:0] hit_slot, slot;
  logic [VW-1:0] bv_cur, bv_end, vstart_q, vpos_n;
  logic [IW-1:0] bi_cur, bi_end, istart_q, ipos_n;
  logic          split_v, split_s, close_a;
  logic [BATCH_W-1:0] batch_q;
  logic [FW-1:0] fill_base, fill_q;
  logic [VW:0]   vinc;
  logic [IW:0]   iinc;
  sbts_rec_t     rec_a, rec_q, rec_b;

  sbts_slot_cam #(
    .TEXTURE_SLOTS(TEXTURE_SLOTS)
  ) u_cam (
    .clk     (clk),
    .handle  (image_handle),
    .fill    (fill_r),
    .wr_en   (accept && !hit_eff),
    .wr_slot (slot),
    .hit     (hit),
    .hit_slot(hit_slot)
  );

  always_comb begin
    bv_cur  = vdist(vpos_r, vstart_r);
    bi_cur  = idist(ipos_r, istart_r);
    // batch already at the vertex limit
    split_v = CW'(bv_cur) >= CW'(BATCH_VERTICES);
    hit_eff = hit && !split_v;
    // new texture and no free slot
    split_s = !split_v && !hit && (fill_r >= FW'(TEXTURE_SLOTS));
    close_a = split_v || split_s;

    batch_q   = close_a ? batch_r + BATCH_W'(1) : batch_r;
    vstart_q  = close_a ? vpos_r : vstart_r;
    istart_q  = close_a ? ipos_r : istart_r;
    fill_base = close_a ? '0 : fill_r;
    slot      = hit_eff ? hit_slot : fill_base[SW-1:0];
    fill_q    = hit_eff ? fill_base : fill_base + FW'(1);

    vinc   = {1'b0, vpos_r} + (VW + 1)'(QUAD_VERTS);
    iinc   = {1'b0, ipos_r} + (IW + 1)'(QUAD_INDICES);
    vpos_n = (vinc >= VMOD_L) ? VW'(vinc - VMOD_L) : vinc[VW-1:0];
    ipos_n = (iinc >= IMOD_L) ? IW'(iinc - IMOD_L) : iinc[IW-1:0];
    bv_end = vdist(vpos_n, vstart_q);
    bi_end = idist(ipos_n, istart_q);
  end

  // record builders
  always_comb begin
    rec_a.kind         = REC_CLOSE;
    rec_a.batch        = batch_r;
    rec_a.slot         = '0;
    rec_a.used         = USED_W'(fill_r);
    rec_a.first_vertex = FVERT_W'(vstart_r);
    rec_a.first_index  = FINDEX_W'(istart_r);
    rec_a.vertex_count = VCOUNT_W'(bv_cur);
    rec_a.index_count  = ICOUNT_W'(bi_cur);
    rec_a.last         = 1'b0;

    rec_q.kind         = REC_QUAD;
    rec_q.batch        = batch_q;
    rec_q.slot         = SLOT_W'(slot);
    rec_q.used         = USED_W'(fill_q);
    rec_q.first_vertex = FVERT_W'(vpos_r);
    rec_q.first_index  = FINDEX_W'(ipos_r);
    rec_q.vertex_count = '0;
    rec_q.index_count  = '0;
    rec_q.last         = !frame_end;

    rec_b.kind         = REC_CLOSE;
    rec_b.batch        = batch_q;
    rec_b.slot         = '0;
    rec_b.used         = USED_W'(fill_q);
    rec_b.first_vertex = FVERT_W'(vstart_q);
    rec_b.first_index  = FINDEX_W'(istart_q);
    rec_b.vertex_count = VCOUNT_W'(bv_end);
    rec_b.index_count  = ICOUNT_W'(bi_end);
    rec_b.last         = 1'b1;
  end

  // compact the records, first one in entry 0
  always_comb begin
    load.num = 2'd1 + {1'b0, close_a} + {1'b0, frame_end};
    if (close_a) begin
      load.rec[0] = rec_a;
      load.rec[1] = rec_q;
      load.rec[2] = rec_b;
    end else begin
      load.rec[0] = rec_q;
      load.rec[1] = rec_b;
      load.rec[2] = rec_b;
    end
  end

  always_comb begin
    fill_nxt   = fill_r;
    batch_nxt  = batch_r;
    vpos_nxt   = vpos_r;
    ipos_nxt   = ipos_r;
    vstart_nxt = vstart_r;
    istart_nxt = istart_r;
    if (accept) begin
      if (frame_end) begin
        fill_nxt   = '0;
        batch_nxt  = '0;
        vpos_nxt   = '0;
        ipos_nxt   = '0;
        vstart_nxt = '0;
        istart_nxt = '0;
      end else begin
        fill_nxt   = fill_q;
        batch_nxt  = batch_q;
        vpos_nxt   = vpos_n;
        ipos_nxt   = ipos_n;
        vstart_nxt = vstart_q;
        istart_nxt = istart_q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r   <= '0;
      batch_r  <= '0;
      vpos_r   <= '0;
      ipos_r   <= '0;
      vstart_r <= '0;
      istart_r <= '0;
    end else begin
      fill_r   <= fill_nxt;
      batch_r  <= batch_nxt;
      vpos_r   <= vpos_nxt;
      ipos_r   <= ipos_nxt;
      vstart_r <= vstart_nxt;
      istart_r <= istart_nxt;
    end
  end

endmodule : sbts_batch_ctrl
`default_nettype wire

[sv/sbts_rec_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbts_rec_queue
// result register holding the records of one quad, drained one per cycle while head_ready is high
// ----------------------------------------------------------------------------
module sbts_rec_queue
  import sbts_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       load_en,
  input  wire sbts_load_t load,
  output logic            load_ready,
  output logic            head_valid,
  input  wire logic       head_ready,
  output sbts_rec_t       head
);

  sbts_rec_t  rec_r [MAX_RECS];
  sbts_rec_t  rec_nxt [MAX_RECS];
  logic [1:0] cnt_r, cnt_nxt;
  logic       fire;

  assign head_valid = (cnt_r != 2'd0);
  assign head       = rec_r[0];
  assign fire       = head_valid && head_ready;
  // take a new quad once the final record of the previous one is leaving
  assign load_ready = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && head_ready);

  always_comb begin
    cnt_nxt = cnt_r;
    for (int i = 0; i < MAX_RECS; i++) begin
      rec_nxt[i] = rec_r[i];
    end
    if (load_en) begin
      cnt_nxt = load.num;
      for (int i = 0; i < MAX_RECS; i++) begin
        rec_nxt[i] = load.rec[i];
      end
    end else if (fire) begin
      cnt_nxt = cnt_r - 2'd1;
      for (int i = 0; i < MAX_RECS - 1; i++) begin
        rec_nxt[i] = rec_r[i+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_RECS; i++) begin
      rec_r[i] <= rec_nxt[i];
    end
  end

endmodule : sbts_rec_queue
`default_nettype wire

[sv/sprite_batch_texture_slotter_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sprite_batch_texture_slotter_unit
// splits a sorted stream of sprite quads into texture-slotted draw batches
// ----------------------------------------------------------------------------
// usage
//   in_*  : one sprite quad per word, texture handle in tdata, tlast on the
//           last quad of a frame
//   out_* : one quad record per quad, plus a batch close record before it
//           when the batch splits and after it on the frame's last quad;
//           tuser gives the record kind, tlast marks the last record of a quad
// the first record of a quad is on out_* in the cycle after acceptance
// throughput: one quad per cycle while each quad gives one record and
//   out_tready is high; a quad with two or three records holds in_tready
//   low until the register drains them, one per cycle with out_tready high
// the texture lookup compares all occupied slots in parallel in the cycle
//   the quad is accepted, and a texture new to the batch is stored in that cycle
// reset clears the batch state and the record register; slot contents are
//   not cleared, as only slots below the fill count are ever compared
// a stall on out_tready holds the current record; in_tready drops as soon as
//   more than the leaving record is still waiting
// a quad with in_tlast set closes the batch and returns the block to its
//   reset state for the next frame
// ----------------------------------------------------------------------------
module sprite_batch_texture_slotter_unit
  import sbts_pkg::*;
#(
  parameter int BATCH_VERTICES = BATCH_VERTICES_DEF,
  parameter int TEXTURE_SLOTS  = TEXTURE_SLOTS_DEF,
  parameter int FRAME_QUADS    = FRAME_QUADS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // input words
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [HANDLE_W-1:0]    in_tdata,   // image_handle
  input  wire logic                   in_tlast,   // frame_end
  // result words
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // batch_number, texture_slot, slots_used, first_vertex, first_index,
  // vertex_count, index_count, zero fill
  output logic [OUT_TDATA_W-1:0]      out_tdata,
  output logic                        out_tuser,  // record_kind
  output logic                        out_tlast   // last
);

  sbts_load_t load;
  sbts_rec_t  head;
  logic       in_accept;

  assign in_accept = in_tvalid && in_tready;

  // batch state, slot lookup and record building
  sbts_batch_ctrl #(
    .BATCH_VERTICES(BATCH_VERTICES),
    .TEXTURE_SLOTS (TEXTURE_SLOTS),
    .FRAME_QUADS   (FRAME_QUADS)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (in_accept),
    .image_handle(in_tdata),
    .frame_end   (in_tlast),
    .load        (load)
  );

  // result register, drained one record per word
  sbts_rec_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .load_en   (in_accept),
    .load      (load),
    .load_ready(in_tready),
    .head_valid(out_tvalid),
    .head_ready(out_tready),
    .head      (head)
  );

  // pack the record, first field lowest
  assign out_tdata = {{OUT_PAD_W{1'b0}}, head.index_count, head.vertex_count,
                      head.first_index, head.first_vertex, head.used,
                      head.slot, head.batch};
  assign out_tuser = head.kind;
  assign out_tlast = head.last;

  // ready for a quad only when at most the final record of the last one waits
  a_ready_drained: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> (!out_tvalid || (out_tready && out_tlast)))
    else $error("input ready while earlier records still pending");

  // every accepted quad yields a record in the next cycle
  a_accept_gives_record: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> out_tvalid)
    else $error("accepted quad produced no record");

  // quad records carry no counts
  a_quad_no_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser == REC_QUAD)) |->
      (head.vertex_count == '0 && head.index_count == '0))
    else $error("quad record with non-zero counts");

endmodule : sprite_batch_texture_slotter_unit
`default_nettype wire

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the sprite batch texture slotter
// ----------------------------------------------------------------------------
// quads are sent as words on in_*, records read back on out_* and compared
// field by field with a local model of the batching rules; a short table of
// directed quads comes first, some rows with their records typed in, then
// random frames, noise and frames of fresh textures that run out of slots,
// under three patterns of idling on both sides
// ----------------------------------------------------------------------------
module tb;
  import sbts_pkg::*;

  localparam int VERT_WRAP    = QUAD_VERTS * FRAME_QUADS_DEF;
  localparam int INDEX_WRAP   = QUAD_INDICES * FRAME_QUADS_DEF;
  localparam int QUIET_LIMIT  = 2000;  // cycles with no word moved on either side
  localparam int SETTLE_WAIT  = 16;

  localparam sbts_rec_t  NO_REC         = '0;
  localparam sbts_load_t FROM_PREDICTOR = '0;

  typedef struct {
    logic [HANDLE_W-1:0] handle;
    logic                frame_end;
    sbts_load_t          answer;   // num of zero: records come from the model
  } stim_row_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [HANDLE_W-1:0]    in_tdata = '0;
  logic                   in_tlast = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;
  logic                   out_tlast;

  // model state of the current batch and frame
  logic [HANDLE_W-1:0] slot_image [TEXTURE_SLOTS_DEF];
  int unsigned         fill_count;
  int unsigned         batch_no;
  int unsigned         vert_pos;
  int unsigned         index_pos;
  int unsigned         vert_start;
  int unsigned         index_start;

  sbts_rec_t   records_due [$];   // records still owed by the block, oldest first
  sbts_load_t  answers_due [$];   // one entry per quad on its way in
  stim_row_t   directed_rows [$];
  int unsigned send_idle_pct = 17;
  int unsigned recv_idle_pct = 67;
  int unsigned error_count = 0;
  int unsigned quiet_cycles = 0;

  sprite_batch_texture_slotter_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- model --

  function automatic sbts_rec_t make_rec(input rec_kind_t kind,
                                         input int unsigned batch, slot, used,
                                         input int unsigned fv, fi, vc, ic);
    sbts_rec_t r;
    r.kind         = kind;
    r.batch        = BATCH_W'(batch);
    r.slot         = SLOT_W'(slot);
    r.used         = USED_W'(used);
    r.first_vertex = FVERT_W'(fv);
    r.first_index  = FINDEX_W'(fi);
    r.vertex_count = VCOUNT_W'(vc);
    r.index_count  = ICOUNT_W'(ic);
    r.last         = 1'b0;
    return r;
  endfunction

  // start of frame; slot contents are left alone as only filled slots count
  function automatic void clear_frame();
    fill_count  = 0;
    batch_no    = 0;
    vert_pos    = 0;
    index_pos   = 0;
    vert_start  = 0;
    index_start = 0;
  endfunction

  // vertices in the open batch, taken modulo the frame's vertex range
  function automatic int unsigned batch_vertices();
    return (vert_pos + VERT_WRAP - vert_start) % VERT_WRAP;
  endfunction

  function automatic sbts_rec_t close_record();
    return make_rec(REC_CLOSE, batch_no, 0, fill_count, vert_start, index_start,
                    batch_vertices(),
                    (index_pos + INDEX_WRAP - index_start) % INDEX_WRAP);
  endfunction

  function automatic void open_next_batch();
    batch_no    = (batch_no + 1) % (1 << BATCH_W);
    fill_count  = 0;
    vert_start  = vert_pos;
    index_start = index_pos;
  endfunction

  // records caused by one quad: split close, quad record, frame close
  function automatic sbts_load_t slot_quad(input logic [HANDLE_W-1:0] handle,
                                           input logic frame_end);
    sbts_load_t  load;
    int unsigned slot;
    bit          hit;
    load = '0;
    slot = 0;
    hit  = 1'b0;
    // vertex limit reached: close before placing the quad
    if (batch_vertices() >= BATCH_VERTICES_DEF) begin
      load.rec[load.num] = close_record();
      load.num++;
      open_next_batch();
    end
    for (int i = 0; i < TEXTURE_SLOTS_DEF; i++) begin
      if (!hit && i < fill_count && slot_image[i] == handle) begin
        slot = i;
        hit  = 1'b1;
      end
    end
    if (!hit) begin
      // new texture with every slot taken
      if (fill_count >= TEXTURE_SLOTS_DEF) begin
        load.rec[load.num] = close_record();
        load.num++;
        open_next_batch();
      end
      slot = fill_count;
      slot_image[slot % TEXTURE_SLOTS_DEF] = handle;
      fill_count++;
    end
    load.rec[load.num] = make_rec(REC_QUAD, batch_no, slot, fill_count, vert_pos,
                                  index_pos, 0, 0);
    load.num++;
    vert_pos  = (vert_pos + QUAD_VERTS) % VERT_WRAP;
    index_pos = (index_pos + QUAD_INDICES) % INDEX_WRAP;
    if (frame_end) begin
      load.rec[load.num] = close_record();
      load.num++;
      clear_frame();
    end
    load.rec[load.num - 1].last = 1'b1;
    return load;
  endfunction

  // ------------------------------------------------------------- checking --

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t ns: %s got 0x%0h want 0x%0h", $time, what, got, want);
    error_count++;
  endtask

  // quads are modelled and records compared in one process, at the edge
  always @(posedge clk) begin
    sbts_load_t             answer;
    sbts_load_t             modelled;
    sbts_rec_t              got;
    sbts_rec_t              want;
    logic [OUT_PAD_W-1:0]   zero_bits;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        answer   = answers_due.pop_front();
        modelled = slot_quad(in_tdata, in_tlast);
        // typed-in rows override the model, the model state still advances
        if (answer.num != 0) modelled = answer;
        for (int k = 0; k < modelled.num; k++) begin
          records_due.insert(records_due.size(), modelled.rec[k]);
        end
      end
      if (out_tvalid && out_tready) begin
        got.kind = rec_kind_t'(out_tuser);
        got.last = out_tlast;
        {zero_bits, got.index_count, got.vertex_count, got.first_index,
         got.first_vertex, got.used, got.slot, got.batch} = out_tdata;
        if (records_due.size() == 0) begin
          report_mismatch("word with no record due, batch", got.batch, 0);
        end else begin
          want = records_due.pop_front();
          if (got.kind !== want.kind) report_mismatch("record_kind", got.kind, want.kind);
          if (got.batch !== want.batch) report_mismatch("batch_number", got.batch, want.batch);
          if (got.slot !== want.slot) report_mismatch("texture_slot", got.slot, want.slot);
          if (got.used !== want.used) report_mismatch("slots_used", got.used, want.used);
          if (got.first_vertex !== want.first_vertex)
            report_mismatch("first_vertex", got.first_vertex, want.first_vertex);
          if (got.first_index !== want.first_index)
            report_mismatch("first_index", got.first_index, want.first_index);
          if (got.vertex_count !== want.vertex_count)
            report_mismatch("vertex_count", got.vertex_count, want.vertex_count);
          if (got.index_count !== want.index_count)
            report_mismatch("index_count", got.index_count, want.index_count);
          if (got.last !== want.last) report_mismatch("last", got.last, want.last);
          if (zero_bits !== '0) report_mismatch("zero fill", zero_bits, 0);
        end
      end
    end
  end

  // receiver back-pressure at the current rate
  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // watchdog on words moved
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("sprite_batch_texture_slotter_unit: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ------------------------------------------------------------- stimulus --

  // one quad word, with random gaps ahead of it; returns at its accepting edge
  task automatic push_quad(input logic [HANDLE_W-1:0] handle, input logic frame_end,
                           input sbts_load_t answer);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    answers_due.insert(answers_due.size(), answer);
    in_tvalid <= 1'b1;
    in_tdata  <= handle;
    in_tlast  <= frame_end;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic add_row(input logic [HANDLE_W-1:0] handle, input logic frame_end,
                         input int unsigned n, input sbts_rec_t r0, r1, r2);
    stim_row_t row;
    row.handle        = handle;
    row.frame_end     = frame_end;
    row.answer        = '0;
    row.answer.num    = 2'(n);
    row.answer.rec[0] = r0;
    row.answer.rec[1] = r1;
    row.answer.rec[2] = r2;
    if (n != 0) row.answer.rec[n - 1].last = 1'b1;
    directed_rows.insert(directed_rows.size(), row);
  endtask

  // a well-formed frame: handles drawn from a pool, frame end on the last quad
  task automatic send_frame(input int unsigned len, input int unsigned distinct);
    logic [HANDLE_W-1:0] pool [$];
    repeat (distinct) begin
      pool.insert(pool.size(),
                  ($urandom_range(0, 7) == 0) ? {HANDLE_W{1'b1}} : HANDLE_W'($urandom));
    end
    for (int unsigned q = 1; q <= len; q++) begin
      push_quad(pool[$urandom_range(0, distinct - 1)], q == len, FROM_PREDICTOR);
    end
  endtask

  // a frame of distinct handles, so the slots run out partway through
  task automatic send_slot_frame(input int unsigned len);
    for (int unsigned q = 0; q < len; q++) begin
      push_quad(HANDLE_W'(q * 7 + 3), q == len - 1, FROM_PREDICTOR);
    end
  endtask

  // mostly frames with random content, some loose quads with stray frame ends
  task automatic random_traffic(input int unsigned quota);
    int unsigned sent;
    int unsigned len;
    sent = 0;
    while (sent < quota) begin
      if ($urandom_range(0, 4) != 0) begin
        len = $urandom_range(1, 48);
        send_frame(len, $urandom_range(1, 40));
      end else begin
        len = $urandom_range(1, 8);
        repeat (len) begin
          push_quad(HANDLE_W'($urandom), $urandom_range(0, 9) == 0, FROM_PREDICTOR);
        end
      end
      sent += len;
    end
    // leave the block at a frame boundary
    push_quad(HANDLE_W'($urandom), 1'b1, FROM_PREDICTOR);
  endtask

  initial begin
    clear_frame();
    // first quad after reset and the handle extremes, read straight off the rules
    add_row(16'h0000, 1'b0, 1, make_rec(REC_QUAD, 0, 0, 1, 0, 0, 0, 0), NO_REC, NO_REC);
    add_row(16'hFFFF, 1'b1, 2, make_rec(REC_QUAD, 0, 1, 2, 4, 6, 0, 0),
            make_rec(REC_CLOSE, 0, 0, 2, 0, 0, 8, 12), NO_REC);
    // one-quad frame straight after a frame end
    add_row(16'hFFFF, 1'b1, 2, make_rec(REC_QUAD, 0, 0, 1, 0, 0, 0, 0),
            make_rec(REC_CLOSE, 0, 0, 1, 0, 0, 4, 6), NO_REC);
    // slot reuse, alternating bit patterns, single-bit handles
    add_row(16'hAAAA, 1'b0, 0, NO_REC, NO_REC, NO_REC);
    add_row(16'h5555, 1'b0, 0, NO_REC, NO_REC, NO_REC);
    add_row(16'hAAAA, 1'b0, 0, NO_REC, NO_REC, NO_REC);
    add_row(16'h5555, 1'b0, 0, NO_REC, NO_REC, NO_REC);
    add_row(16'h0001, 1'b0, 0, NO_REC, NO_REC, NO_REC);
    add_row(16'h8000, 1'b0, 0, NO_REC, NO_REC, NO_REC);
    add_row(16'hFFFF, 1'b0, 0, NO_REC, NO_REC, NO_REC);
    add_row(16'h0000, 1'b0, 0, NO_REC, NO_REC, NO_REC);
    add_row(16'h0000, 1'b1, 0, NO_REC, NO_REC, NO_REC);
    add_row(16'h00FF, 1'b0, 0, NO_REC, NO_REC, NO_REC);
    add_row(16'hFF00, 1'b0, 0, NO_REC, NO_REC, NO_REC);
    add_row(16'h00FF, 1'b1, 0, NO_REC, NO_REC, NO_REC);
    add_row(16'h7FFF, 1'b0, 0, NO_REC, NO_REC, NO_REC);
    add_row(16'hFFFE, 1'b1, 0, NO_REC, NO_REC, NO_REC);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // sender gaps light, receiver stalls heavy
    foreach (directed_rows[i]) begin
      push_quad(directed_rows[i].handle, directed_rows[i].frame_end,
                directed_rows[i].answer);
    end
    random_traffic(65);
    // more fresh textures than slots: a split for lack of a free slot
    send_slot_frame(36);

    // sender gaps heavy, receiver stalls light
    send_idle_pct = 67;
    recv_idle_pct = 17;
    random_traffic(65);
    send_frame(48, 40);

    // no idling
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_traffic(65);
    in_tvalid <= 1'b0;

    while (records_due.size() != 0) @(posedge clk);
    repeat (SETTLE_WAIT) @(posedge clk);
    if (error_count == 0) begin
      $display("sprite_batch_texture_slotter_unit: match");
    end else begin
      $display("sprite_batch_texture_slotter_unit: mismatch");
    end
    $finish;
  end

endmodule

[sprite_batch_texture_slotter_unit.f]
sv/sbts_pkg.sv
sv/sbts_slot_cam.sv
sv/sbts_batch_ctrl.sv
sv/sbts_rec_queue.sv
sv/sprite_batch_texture_slotter_unit.sv
tb/tb.sv
